### hdl/bsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booth multiplier package
// Operand widths and the word that each Booth cell hands on to the next.
// ----------------------------------------------------------------------------
package bsm_pkg;

	localparam int WIDTH  = 8;
	localparam int ACC_W  = WIDTH + 1;
	localparam int PROD_W = 2 * WIDTH;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [WIDTH-1:0] q;
		logic             extra;
		logic [ACC_W-1:0] mcand;
	} bsm_stage_t;

endpackage

### hdl/bsm_op_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel carrying one multiplicand and multiplier pair.
// ----------------------------------------------------------------------------
interface bsm_op_if;
	import bsm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] multiplicand;
	logic signed [WIDTH-1:0] multiplier;

	modport source (output valid, output multiplicand, output multiplier, input ready);
	modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

### hdl/bsm_prod_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Product channel
// Valid/ready channel carrying one signed product.
// ----------------------------------------------------------------------------
interface bsm_prod_if;
	import bsm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [PROD_W-1:0] product;

	modport source (output valid, output product, input ready);
	modport sink   (input valid, input product, output ready);
endinterface

### hdl/bsm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booth cell
// One radix-2 Booth step (add, subtract or keep, then arithmetic shift right)
// followed by a stage register with its own valid and a local ready.
// ----------------------------------------------------------------------------
module bsm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	input  bsm_pkg::bsm_stage_t up_data,
	output logic               up_ready,
	output logic               dn_valid,
	output bsm_pkg::bsm_stage_t dn_data,
	input  logic               dn_ready
);
	import bsm_pkg::*;

	logic             vld_q;
	bsm_stage_t       data_q;
	bsm_stage_t       step;
	logic [ACC_W-1:0] acc_sum;

	always_comb begin
		case ({up_data.q[0], up_data.extra})
			2'b10:   acc_sum = up_data.acc - up_data.mcand;
			2'b01:   acc_sum = up_data.acc + up_data.mcand;
			default: acc_sum = up_data.acc;
		endcase
		step.mcand = up_data.mcand;
		step.extra = up_data.q[0];
		step.q     = {acc_sum[0], up_data.q[WIDTH-1:1]};
		step.acc   = {acc_sum[ACC_W-1], acc_sum[ACC_W-1:1]};
	end

	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	// advance payload on a taken request
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= step;
		end
	end

	assign dn_valid = vld_q;
	assign dn_data  = data_q;

endmodule

### hdl/booth_signed_multiplier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booth signed multiplier core
// Pipelined radix-2 Booth multiplier built as a chain of step cells.
// ----------------------------------------------------------------------------
// A chain of WIDTH identical cells, one per Booth step, each with its own
// stage register. A new operand request is taken every cycle unless result
// back-pressure stalls the chain, and its product passes each cell's register
// in turn; throughput is one product per cycle when not stalled, set by the
// single step each cell performs. The last cell's register is the output
// register, and every cell keeps its own ready, so new requests enter while
// a finished product waits downstream until the chain is full.
module booth_signed_multiplier_core (
	input  logic       clk,
	input  logic       arst_n,
	bsm_op_if.sink     operand,
	bsm_prod_if.source result
);
	import bsm_pkg::*;

	logic       vld   [WIDTH+1];
	logic       rdy   [WIDTH+1];
	bsm_stage_t data  [WIDTH+1];

	always_comb begin
		data[0].acc   = '0;
		data[0].q     = operand.multiplier;
		data[0].extra = 1'b0;
		data[0].mcand = {operand.multiplicand[WIDTH-1], operand.multiplicand};
	end

	assign vld[0]        = operand.valid;
	assign operand.ready = rdy[0];

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		bsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_data  (data[i]),
			.up_ready (rdy[i]),
			.dn_valid (vld[i+1]),
			.dn_data  (data[i+1]),
			.dn_ready (rdy[i+1])
		);
	end

	assign rdy[WIDTH]     = result.ready;
	assign result.valid   = vld[WIDTH];
	assign result.product = {data[WIDTH].acc[WIDTH-1:0], data[WIDTH].q};

	a_take_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		operand.valid && operand.ready |=> vld[1])
		else $error("accepted request did not reach first cell");

	a_empty_first_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[1] |-> operand.ready)
		else $error("empty first cell refused a request");

	a_stall_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		vld[WIDTH] && !result.ready && vld[WIDTH-1] |=> vld[WIDTH-1] && vld[WIDTH])
		else $error("stalled chain dropped a request");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booth signed multiplier core testbench
// Feeds operand pairs through the valid/ready operand channel, with corner
// cases first and then random pairs, and drains the product channel with
// random back-pressure. Each accepted pair is multiplied by a bit-level
// radix-2 Booth model in the bench, and every accepted product is compared
// in order against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module testbench;
	import bsm_pkg::*;

	localparam int IDLE_PCT      = 19;
	localparam int RANDOM_ITEMS  = 950;
	localparam int STALL_LIMIT   = 2000;
	localparam int QUIET_FROM    = 400;
	localparam int QUIET_TO      = 650;
	localparam logic [1:0] PAIR_ADD = 2'b01;
	localparam logic [1:0] PAIR_SUB = 2'b10;

	typedef struct {
		logic signed [WIDTH-1:0] multiplicand;
		logic signed [WIDTH-1:0] multiplier;
		bit                      drain;
	} op_req_t;

	logic clk;
	logic arst_n;

	bsm_op_if   op_ch ();
	bsm_prod_if prod_ch ();

	booth_signed_multiplier_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (op_ch),
		.result  (prod_ch)
	);

	op_req_t                  operand_queue[$];
	logic signed [PROD_W-1:0] pending_products[$];
	op_req_t                  next_req;
	logic signed [PROD_W-1:0] want;
	int                       taken;
	int                       seen;
	int                       errors;
	int                       stall_cycles;
	bit                       quiet;

	assign quiet = (taken >= QUIET_FROM) && (taken < QUIET_TO);

	function automatic logic signed [PROD_W-1:0] booth_product(
		input logic signed [WIDTH-1:0] mcand,
		input logic signed [WIDTH-1:0] mplier
	);
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] m;
		logic [WIDTH-1:0] q;
		logic             extra;
		acc   = '0;
		m     = {mcand[WIDTH-1], mcand};
		q     = mplier;
		extra = 1'b0;
		for (int i = 0; i < WIDTH; i++) begin
			case ({q[0], extra})
				PAIR_SUB: acc = acc - m;
				PAIR_ADD: acc = acc + m;
				default: ;
			endcase
			{acc, q, extra} = {acc[ACC_W-1], acc, q};
		end
		return {acc[WIDTH-1:0], q};
	endfunction

	function automatic logic signed [WIDTH-1:0] random_operand();
		case ($urandom_range(9))
			0: return {1'b1, {(WIDTH-1){1'b0}}};
			1: return {1'b0, {(WIDTH-1){1'b1}}};
			2: return '0;
			3: return '1;
			4: return WIDTH'(1);
			default: return WIDTH'($urandom);
		endcase
	endfunction

	task automatic queue_request(input int a, input int b, input bit drain);
		op_req_t r;
		r.multiplicand = WIDTH'(a);
		r.multiplier   = WIDTH'(b);
		r.drain        = drain;
		operand_queue.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_ch.valid <= 1'b0;
		end else if (!op_ch.valid || op_ch.ready) begin
			if (operand_queue.size() != 0
					&& (!operand_queue[0].drain || (!op_ch.valid && taken == seen))
					&& (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = operand_queue.pop_front();
				op_ch.valid        <= 1'b1;
				op_ch.multiplicand <= next_req.multiplicand;
				op_ch.multiplier   <= next_req.multiplier;
			end else begin
				op_ch.valid <= 1'b0;
			end
		end
	end

	// product monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_ch.ready <= 1'b0;
			taken         <= 0;
			seen          <= 0;
		end else begin
			if (op_ch.valid && op_ch.ready) begin
				pending_products.push_back(booth_product(op_ch.multiplicand,
					op_ch.multiplier));
				taken <= taken + 1;
			end
			if (prod_ch.valid && prod_ch.ready) begin
				seen <= seen + 1;
				if (pending_products.size() == 0) begin
					errors++;
					$display("%0t: unexpected product, expected none, actual %0d",
						$time, prod_ch.product);
				end else begin
					want = pending_products.pop_front();
					if (prod_ch.product !== want) begin
						errors++;
						$display("%0t: product mismatch, expected %0d, actual %0d",
							$time, want, prod_ch.product);
					end
				end
			end
			prod_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (!arst_n || (op_ch.valid && op_ch.ready) || (prod_ch.valid && prod_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		op_ch.valid        = 1'b0;
		op_ch.multiplicand = '0;
		op_ch.multiplier   = '0;
		prod_ch.ready      = 1'b0;
		arst_n             = 1'b0;
		errors             = 0;
		stall_cycles       = 0;

		// corners, most negative operands and every Booth pair pattern
		queue_request(-128, -128, 1'b0);
		queue_request(-128,  127, 1'b0);
		queue_request( 127, -128, 1'b0);
		queue_request( 127,  127, 1'b0);
		queue_request(   0,    0, 1'b0);
		queue_request(   0, -128, 1'b0);
		queue_request(-128,    0, 1'b0);
		queue_request(   1,   -1, 1'b0);
		queue_request(  -1,   -1, 1'b0);
		queue_request(  -1,    1, 1'b0);
		queue_request(-128,   -1, 1'b0);
		queue_request(  -1, -128, 1'b0);
		queue_request( 127,    1, 1'b0);
		queue_request(   1,  127, 1'b0);
		queue_request(  37,   85, 1'b0);
		queue_request( -37,   85, 1'b0);
		queue_request(  37,  -86, 1'b0);
		queue_request( -99,  -86, 1'b0);
		queue_request( 100,   64, 1'b0);
		queue_request(-100,  -64, 1'b0);
		queue_request(   3,   -2, 1'b0);
		queue_request(  -5,    7, 1'b0);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_request(int'(random_operand()), int'(random_operand()),
				i == 0 || i == RANDOM_ITEMS / 2);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (operand_queue.size() != 0 || op_ch.valid || taken != seen)
			@(posedge clk);
		repeat (4 * WIDTH) @(posedge clk);

		if (errors == 0 && pending_products.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
